// ===== sv/cfsk_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cfsk_pkg;

   localparam int SAMPLE_WIDTH = 16;
   localparam int TONE_WIDTH   = 16;
   localparam int PHASE_WIDTH  = 32;
   localparam int SINE_DEPTH   = 1024;
   localparam int SINE_ADDR_W  = $clog2(SINE_DEPTH);
   localparam int COUNT_WIDTH  = 16;
   localparam int PROD_WIDTH   = SAMPLE_WIDTH + TONE_WIDTH;
   localparam int SUM_WIDTH    = 48;
   localparam int CSR_DATA_W   = 32;
   localparam int CSR_INDEX_W  = 2;
   localparam int LINK_DEPTH   = 4;
   localparam int LINK_PTR_W   = $clog2(LINK_DEPTH);
   localparam int OUT_DEPTH    = 8;
   localparam int OUT_PTR_W    = $clog2(OUT_DEPTH);

   localparam logic [PHASE_WIDTH-1:0] STEP_LOW_RESET  = 32'd223696213;
   localparam logic [PHASE_WIDTH-1:0] STEP_HIGH_RESET = 32'd268435456;
   localparam logic [COUNT_WIDTH-1:0] SPB_RESET       = 16'd307;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_STEP_LOW  = 2'd0,
      CSR_STEP_HIGH = 2'd1,
      CSR_SPB       = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] sample;
      logic [SINE_ADDR_W-1:0]         idx_low;
      logic [SINE_ADDR_W-1:0]         idx_high;
      logic                           last;
      logic                           partial;
   } link_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic bit_value;
      logic partial_block;
   } result_type;

   typedef logic signed [TONE_WIDTH-1:0] sine_tab_type [SINE_DEPTH];

   localparam logic [63:0] Q30_ONE     = 64'h4000_0000;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic signed [63:0] TONE_PEAK = 64'sd32767;
   localparam logic [63:0] TAYLOR_DIV [1:5] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110};

   // sin(pi/2 * r / 2^30) in Q30, odd Taylor terms up to x^11
   function automatic logic signed [63:0] quarter_sine(input logic [63:0] r);
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic signed [63:0] sum;
      x    = (r * HALF_PI_Q30) >> 30;
      x2   = (x * x) >> 30;
      term = x;
      sum  = signed'(x);
      for (int n = 1; n <= 5; n++) begin
         term = (term * x2) >> 30;
         term = term / TAYLOR_DIV[n];
         if ((n & 1) != 0) begin
            sum = sum - signed'(term);
         end else begin
            sum = sum + signed'(term);
         end
      end
      return sum;
   endfunction

   function automatic sine_tab_type build_sine_tab();
      sine_tab_type       tab;
      logic [63:0]        a;
      logic [63:0]        r;
      logic [1:0]         q;
      logic signed [63:0] s;
      logic signed [63:0] mag;
      for (int k = 0; k < SINE_DEPTH; k++) begin
         a = (64'(k) << 32) >> SINE_ADDR_W;
         q = a[31:30];
         r = a & (Q30_ONE - 64'd1);
         if (q[0]) begin
            r = Q30_ONE - r;
         end
         s   = quarter_sine(r);
         mag = (s * TONE_PEAK + signed'(Q30_ONE >> 1)) >>> 30;
         if (mag > TONE_PEAK) begin
            mag = TONE_PEAK;
         end
         tab[k] = q[1] ? TONE_WIDTH'(-mag) : TONE_WIDTH'(mag);
      end
      return tab;
   endfunction

   localparam sine_tab_type SINE_TAB = build_sine_tab();

endpackage

`default_nettype wire

// ===== sv/cfsk_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cfsk_front (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    accept,
   input  wire logic signed [cfsk_pkg::SAMPLE_WIDTH-1:0] req_sample,
   input  wire logic                                    req_flush,
   input  wire logic                                    csr_we,
   input  wire logic [cfsk_pkg::CSR_INDEX_W-1:0]         csr_index,
   input  wire logic [cfsk_pkg::CSR_DATA_W-1:0]          csr_data,
   output cfsk_pkg::link_type                           link_entry
);

   logic [cfsk_pkg::PHASE_WIDTH-1:0] step_low_ff, step_low_in;
   logic [cfsk_pkg::PHASE_WIDTH-1:0] step_high_ff, step_high_in;
   logic [cfsk_pkg::COUNT_WIDTH-1:0] spb_ff, spb_in;
   logic [cfsk_pkg::PHASE_WIDTH-1:0] phase_low_ff, phase_low_in;
   logic [cfsk_pkg::PHASE_WIDTH-1:0] phase_high_ff, phase_high_in;
   logic [cfsk_pkg::COUNT_WIDTH-1:0] count_ff, count_in;

   logic [cfsk_pkg::COUNT_WIDTH-1:0] count_inc;
   logic [cfsk_pkg::COUNT_WIDTH-1:0] count_sat;
   logic [cfsk_pkg::COUNT_WIDTH-1:0] limit;
   logic                             close;
   logic                             short_block;

   always_comb begin
      step_low_in  = step_low_ff;
      step_high_in = step_high_ff;
      spb_in       = spb_ff;
      if (csr_we) begin
         case (cfsk_pkg::csr_index_type'(csr_index))
            cfsk_pkg::CSR_STEP_LOW: begin
               step_low_in = csr_data[cfsk_pkg::PHASE_WIDTH-1:0];
            end
            cfsk_pkg::CSR_STEP_HIGH: begin
               step_high_in = csr_data[cfsk_pkg::PHASE_WIDTH-1:0];
            end
            cfsk_pkg::CSR_SPB: begin
               spb_in = csr_data[cfsk_pkg::COUNT_WIDTH-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // hold the count at all ones instead of wrapping to zero
   assign count_inc   = count_ff + 1'b1;
   assign count_sat   = (count_inc == '0) ? '1 : count_inc;
   assign limit       = (spb_ff == '0) ? cfsk_pkg::COUNT_WIDTH'(1) : spb_ff;
   assign short_block = count_sat < limit;
   assign close       = !short_block || req_flush;

   always_comb begin
      phase_low_in  = phase_low_ff;
      phase_high_in = phase_high_ff;
      count_in      = count_ff;
      if (accept) begin
         phase_low_in  = phase_low_ff + step_low_ff;
         phase_high_in = phase_high_ff + step_high_ff;
         count_in      = close ? '0 : count_sat;
      end
   end

   always_comb begin
      link_entry.sample   = req_sample;
      link_entry.idx_low  =
         phase_low_ff[cfsk_pkg::PHASE_WIDTH-1 -: cfsk_pkg::SINE_ADDR_W];
      link_entry.idx_high =
         phase_high_ff[cfsk_pkg::PHASE_WIDTH-1 -: cfsk_pkg::SINE_ADDR_W];
      link_entry.last     = close;
      link_entry.partial  = short_block;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_low_ff   <= cfsk_pkg::STEP_LOW_RESET;
         step_high_ff  <= cfsk_pkg::STEP_HIGH_RESET;
         spb_ff        <= cfsk_pkg::SPB_RESET;
         phase_low_ff  <= '0;
         phase_high_ff <= '0;
         count_ff      <= '0;
      end else begin
         step_low_ff   <= step_low_in;
         step_high_ff  <= step_high_in;
         spb_ff        <= spb_in;
         phase_low_ff  <= phase_low_in;
         phase_high_ff <= phase_high_in;
         count_ff      <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/cfsk_link_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cfsk_link_fifo (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire cfsk_pkg::link_type   push_entry,
   input  wire logic                 pop,
   output cfsk_pkg::link_type        head_entry,
   output cfsk_pkg::queue_status_type status
);

   cfsk_pkg::link_type slot_ff [cfsk_pkg::LINK_DEPTH];

   logic [cfsk_pkg::LINK_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [cfsk_pkg::LINK_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [cfsk_pkg::LINK_PTR_W:0]   count_ff, count_in;
   logic                            do_push;
   logic                            do_pop;

   assign status.full  = count_ff == (cfsk_pkg::LINK_PTR_W+1)'(cfsk_pkg::LINK_DEPTH);
   assign status.empty = count_ff == '0;
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_entry   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/cfsk_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cfsk_back (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire cfsk_pkg::link_type         link_head,
   input  wire cfsk_pkg::queue_status_type link_status,
   output logic                            link_pop,
   input  wire logic                       rsp_pop,
   output logic                            rsp_empty,
   output logic                            rsp_bit_value,
   output logic                            rsp_partial_block
);

   // stage 1: tone lookup
   logic                                   s1_valid_ff;
   logic                                   s1_last_ff;
   logic                                   s1_partial_ff;
   logic signed [cfsk_pkg::SAMPLE_WIDTH-1:0] s1_sample_ff;
   logic signed [cfsk_pkg::TONE_WIDTH-1:0]   s1_tone_low_ff;
   logic signed [cfsk_pkg::TONE_WIDTH-1:0]   s1_tone_high_ff;

   // stage 2: products
   logic                                   s2_valid_ff;
   logic                                   s2_last_ff;
   logic                                   s2_partial_ff;
   logic signed [cfsk_pkg::PROD_WIDTH-1:0]   s2_prod_low_ff, s2_prod_low_in;
   logic signed [cfsk_pkg::PROD_WIDTH-1:0]   s2_prod_high_ff, s2_prod_high_in;

   // stage 3: accumulate, latch closing sums
   logic signed [cfsk_pkg::SUM_WIDTH-1:0]    sum_low_ff, sum_low_in;
   logic signed [cfsk_pkg::SUM_WIDTH-1:0]    sum_high_ff, sum_high_in;
   logic signed [cfsk_pkg::SUM_WIDTH-1:0]    add_low;
   logic signed [cfsk_pkg::SUM_WIDTH-1:0]    add_high;
   logic signed [cfsk_pkg::SUM_WIDTH-1:0]    fin_low_ff;
   logic signed [cfsk_pkg::SUM_WIDTH-1:0]    fin_high_ff;
   logic                                   dec_valid_ff;
   logic                                   dec_partial_ff;

   // result queue
   cfsk_pkg::result_type               out_slot_ff [cfsk_pkg::OUT_DEPTH];
   cfsk_pkg::result_type               out_entry;
   logic [cfsk_pkg::OUT_PTR_W-1:0]     out_wr_ff, out_wr_in;
   logic [cfsk_pkg::OUT_PTR_W-1:0]     out_rd_ff, out_rd_in;
   logic [cfsk_pkg::OUT_PTR_W:0]       out_count_ff, out_count_in;
   logic [cfsk_pkg::OUT_PTR_W:0]       pending;
   logic                               out_pop;

   // take a beat only if the result queue has room for every decision in flight
   assign pending = out_count_ff
                    + (cfsk_pkg::OUT_PTR_W+1)'(s1_last_ff)
                    + (cfsk_pkg::OUT_PTR_W+1)'(s2_last_ff)
                    + (cfsk_pkg::OUT_PTR_W+1)'(dec_valid_ff);
   assign link_pop = !link_status.empty
                     && (pending < (cfsk_pkg::OUT_PTR_W+1)'(cfsk_pkg::OUT_DEPTH));

   always_ff @(posedge clock) begin
      s1_sample_ff    <= link_head.sample;
      s1_partial_ff   <= link_head.partial;
      s1_tone_low_ff  <= cfsk_pkg::SINE_TAB[link_head.idx_low];
      s1_tone_high_ff <= cfsk_pkg::SINE_TAB[link_head.idx_high];
   end

   assign s2_prod_low_in  = s1_sample_ff * s1_tone_low_ff;
   assign s2_prod_high_in = s1_sample_ff * s1_tone_high_ff;

   always_ff @(posedge clock) begin
      s2_prod_low_ff  <= s2_prod_low_in;
      s2_prod_high_ff <= s2_prod_high_in;
      s2_partial_ff   <= s1_partial_ff;
   end

   assign add_low  = sum_low_ff + cfsk_pkg::SUM_WIDTH'(s2_prod_low_ff);
   assign add_high = sum_high_ff + cfsk_pkg::SUM_WIDTH'(s2_prod_high_ff);

   always_comb begin
      sum_low_in  = sum_low_ff;
      sum_high_in = sum_high_ff;
      if (s2_valid_ff) begin
         sum_low_in  = s2_last_ff ? '0 : add_low;
         sum_high_in = s2_last_ff ? '0 : add_high;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_valid_ff && s2_last_ff) begin
         fin_low_ff     <= add_low;
         fin_high_ff    <= add_high;
         dec_partial_ff <= s2_partial_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s1_last_ff   <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s2_last_ff   <= 1'b0;
         sum_low_ff   <= '0;
         sum_high_ff  <= '0;
         dec_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= link_pop;
         s1_last_ff   <= link_pop && link_head.last;
         s2_valid_ff  <= s1_valid_ff;
         s2_last_ff   <= s1_last_ff;
         sum_low_ff   <= sum_low_in;
         sum_high_ff  <= sum_high_in;
         dec_valid_ff <= s2_valid_ff && s2_last_ff;
      end
   end

   // stage 4: decide and queue the result
   always_comb begin
      out_entry.bit_value     = fin_high_ff > fin_low_ff;
      out_entry.partial_block = dec_partial_ff;
   end

   assign rsp_empty         = out_count_ff == '0;
   assign out_pop           = rsp_pop && !rsp_empty;
   assign rsp_bit_value     = out_slot_ff[out_rd_ff].bit_value;
   assign rsp_partial_block = out_slot_ff[out_rd_ff].partial_block;

   always_comb begin
      out_wr_in    = dec_valid_ff ? out_wr_ff + 1'b1 : out_wr_ff;
      out_rd_in    = out_pop ? out_rd_ff + 1'b1 : out_rd_ff;
      out_count_in = out_count_ff;
      if (dec_valid_ff && !out_pop) begin
         out_count_in = out_count_ff + 1'b1;
      end else if (!dec_valid_ff && out_pop) begin
         out_count_in = out_count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (dec_valid_ff) begin
         out_slot_ff[out_wr_ff] <= out_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_wr_ff    <= '0;
         out_rd_ff    <= '0;
         out_count_ff <= '0;
      end else begin
         out_wr_ff    <= out_wr_in;
         out_rd_ff    <= out_rd_in;
         out_count_ff <= out_count_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/coherent_fsk_demodulator.sv =====
// A closing sample passes the link FIFO, back stages and result queue. Throughput: one
// sample per cycle while the link FIFO is not full; the front updates both tone phases
// and the block count, the back pipelines lookup, multiply, accumulate and compare.
// Reset (synchronous): clears phases, sums, count and both queues, and loads the
// register reset values; no clearing pass, so samples are taken in the next cycle.
`timescale 1ns / 1ps
`default_nettype none

module coherent_fsk_demodulator (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    req_push,
   output logic                                         req_full,
   input  wire logic signed [cfsk_pkg::SAMPLE_WIDTH-1:0] req_sample,
   input  wire logic                                    req_flush,
   output logic                                         rsp_empty,
   input  wire logic                                    rsp_pop,
   output logic                                         rsp_bit_value,
   output logic                                         rsp_partial_block,
   input  wire logic                                    csr_we,
   input  wire logic [cfsk_pkg::CSR_INDEX_W-1:0]         csr_index,
   input  wire logic [cfsk_pkg::CSR_DATA_W-1:0]          csr_data
);

   cfsk_pkg::link_type         link_entry;
   cfsk_pkg::link_type         link_head;
   cfsk_pkg::queue_status_type link_status;
   logic                       link_pop;
   logic                       accept;

   assign req_full = link_status.full || reset;
   assign accept   = req_push && !req_full;

   cfsk_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req_sample (req_sample),
      .req_flush  (req_flush),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .link_entry (link_entry)
   );

   cfsk_link_fifo u_link (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .push_entry (link_entry),
      .pop        (link_pop),
      .head_entry (link_head),
      .status     (link_status)
   );

   cfsk_back u_back (
      .clock             (clock),
      .reset             (reset),
      .link_head         (link_head),
      .link_status       (link_status),
      .link_pop          (link_pop),
      .rsp_pop           (rsp_pop),
      .rsp_empty         (rsp_empty),
      .rsp_bit_value     (rsp_bit_value),
      .rsp_partial_block (rsp_partial_block)
   );

endmodule

`default_nettype wire

// ===== sv/cfsk_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cfsk_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic rsp_empty,
   input wire logic rsp_pop,
   input wire logic rsp_bit_value,
   input wire logic rsp_partial_block
);

   a_reset_empties: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result queue not empty after reset");

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
         (!rsp_empty && $stable(rsp_bit_value) && $stable(rsp_partial_block)))
      else $error("stalled result beat changed");

   // no decision can come out faster than the pipeline after reset
   a_no_early_result: assert property (@(posedge clock)
      $fell(rsp_empty) |-> (!$past(reset, 1) && !$past(reset, 2) && !$past(reset, 3)))
      else $error("result appeared too soon after reset");

endmodule

bind coherent_fsk_demodulator cfsk_checker u_cfsk_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_empty         (rsp_empty),
   .rsp_pop           (rsp_pop),
   .rsp_bit_value     (rsp_bit_value),
   .rsp_partial_block (rsp_partial_block)
);

`default_nettype wire
